>>> src/rsht_pkg.sv
package rsht_pkg;

    localparam int TBL_DEPTH = 16;
    localparam int IDX_W     = $clog2(TBL_DEPTH);
    localparam int CNT_W     = 5;

    localparam logic [63:0] MISS_VALUE = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_READ   = 2'd2,
        REQ_WRITE  = 2'd3
    } req_code_t;

    typedef struct packed {
        req_code_t   req_type;
        logic [31:0] reg_index;
        logic [63:0] data_value;
        logic        intercept_reads;
        logic        intercept_writes;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [63:0]      read_value;
        logic [CNT_W-1:0] entry_count;
        logic [63:0]      intercept_total;
    } rsp_t;

    typedef struct packed {
        logic [31:0] key;
        logic [63:0] value;
        logic        rflag;
        logic        wflag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_SHIFT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
        logic shift;
        logic emit;
    } cmd_t;

    typedef struct packed {
        req_code_t req_type;
        logic      found;
        logic      match;
        logic      miss;
        logic      shift_end;
        logic      out_free;
    } sts_t;

endpackage

>>> src/register_shadow_table.sv
// An accepted request scans the filled slots until the key matches or the end is reached,
// then executes; a remove then moves each later entry down one slot, and the result is
// issued once the output is free. One request at a time; the next request is accepted
// the cycle after the result is issued.
// Reset: synchronous, active low; clears the entry count, the intercept counter and
// the handshakes. Table contents are not cleared.
module register_shadow_table (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rsht_pkg::req_t s_req,
    output logic           m_valid,
    input  logic           m_ready,
    output rsht_pkg::rsp_t m_rsp
);

    import rsht_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rsht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rsht_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

endmodule

>>> src/rsht_ram.sv
module rsht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/rsht_ctrl.sv
module rsht_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  rsht_pkg::sts_t sts,
    output rsht_pkg::cmd_t cmd
);

    import rsht_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.match || sts.miss) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (sts.req_type == REQ_REMOVE && sts.found) begin
                    state_next = ST_SHIFT;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (sts.shift_end) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/rsht_dp.sv
module rsht_dp (
    input  logic           aclk,
    input  logic           aresetn,
    input  rsht_pkg::req_t s_req,
    input  rsht_pkg::cmd_t cmd,
    output rsht_pkg::sts_t sts,
    output logic           m_valid,
    input  logic           m_ready,
    output rsht_pkg::rsp_t m_rsp
);

    import rsht_pkg::*;

    req_t             req_reg,      req_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic [63:0]      total_reg,    total_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg,  cmp_idx_next;
    logic             pend_reg,     pend_next;
    logic             found_reg,    found_next;
    logic [IDX_W-1:0] slot_reg,     slot_next;
    entry_t           hold_reg,     hold_next;
    logic             hit_reg,      hit_next;
    logic [63:0]      rval_reg,     rval_next;
    logic             m_valid_reg,  m_valid_next;
    rsp_t             rsp_reg,      rsp_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;

    logic match;
    logic issue;
    logic at_end;

    rsht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign match     = pend_reg && (ram_rdata.key == req_reg.reg_index);
    assign issue     = scan_idx_reg < count_reg;
    assign at_end    = !issue;
    assign ram_raddr = scan_idx_reg[IDX_W-1:0];

    assign sts.req_type  = req_reg.req_type;
    assign sts.found     = found_reg;
    assign sts.match     = match;
    assign sts.miss      = !match && at_end;
    assign sts.shift_end = at_end;
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            total_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            total_reg   <= total_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        slot_reg     <= slot_next;
        hold_reg     <= hold_next;
        hit_reg      <= hit_next;
        rval_reg     <= rval_next;
        rsp_reg      <= rsp_next;
    end

    always_comb begin
        req_next      = req_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        scan_idx_next = scan_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        pend_next     = pend_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        hold_next     = hold_reg;
        hit_next      = hit_reg;
        rval_next     = rval_reg;
        m_valid_next  = m_valid_reg;
        rsp_next      = rsp_reg;
        ram_we        = 1'b0;
        ram_waddr     = slot_reg;
        ram_wdata     = ram_rdata;

        if (cmd.load) begin
            req_next      = s_req;
            scan_idx_next = '0;
            pend_next     = 1'b0;
            hit_next      = 1'b0;
            rval_next     = MISS_VALUE;
        end

        // walk the filled slots, one read issued per cycle
        if (cmd.scan || cmd.shift) begin
            pend_next = issue;
            if (issue) begin
                cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                scan_idx_next = scan_idx_reg + CNT_W'(1);
            end
        end

        if (cmd.scan) begin
            if (match) begin
                found_next = 1'b1;
                slot_next  = cmp_idx_reg;
                hold_next  = ram_rdata;
            end else if (at_end) begin
                found_next = 1'b0;
            end
        end

        if (cmd.exec) begin
            unique case (req_reg.req_type)
                REQ_ADD: begin
                    ram_wdata.key   = req_reg.reg_index;
                    ram_wdata.value = req_reg.data_value;
                    ram_wdata.rflag = req_reg.intercept_reads;
                    ram_wdata.wflag = req_reg.intercept_writes;
                    if (found_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_reg;
                        hit_next  = 1'b1;
                    end else if (count_reg < CNT_W'(TBL_DEPTH)) begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[IDX_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                        hit_next   = 1'b1;
                    end
                end
                REQ_REMOVE: begin
                    scan_idx_next = CNT_W'(slot_reg) + CNT_W'(1);
                    pend_next     = 1'b0;
                end
                REQ_READ: begin
                    if (found_reg && hold_reg.rflag) begin
                        hit_next   = 1'b1;
                        rval_next  = hold_reg.value;
                        total_next = total_reg + 64'd1;
                    end
                end
                REQ_WRITE: begin
                    if (found_reg && hold_reg.wflag) begin
                        hit_next   = 1'b1;
                        total_next = total_reg + 64'd1;
                    end
                end
            endcase
        end

        // move each later entry down one slot
        if (cmd.shift) begin
            if (pend_reg) begin
                ram_we    = 1'b1;
                ram_waddr = cmp_idx_reg - IDX_W'(1);
                ram_wdata = ram_rdata;
            end
            if (at_end) begin
                count_next = count_reg - CNT_W'(1);
                hit_next   = 1'b1;
            end
        end

        if (cmd.emit) begin
            m_valid_next             = 1'b1;
            rsp_next.hit             = hit_reg;
            rsp_next.read_value      = rval_reg;
            rsp_next.entry_count     = count_reg;
            rsp_next.intercept_total = total_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

endmodule
